// ----- sv/bcp_pkg.sv -----
// ----------------------------------------------------------------------------
// Balance cascade PID package
// Widths, constants, register indexes, multiplier operand codes and the
// control bundle shared by the sequencer and the top level.
// ----------------------------------------------------------------------------
package bcp_pkg;

   // Field widths of the stream beats and the register port.
   localparam int GAIN_W     = 32;
   localparam int ANGLE_W    = 18;
   localparam int SPD_W      = 16;
   localparam int RATE_W     = 16;
   localparam int LIM_W      = 8;
   localparam int DRIVE_W    = 14;
   localparam int REQ_W      = 88;
   localparam int RSP_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Internal datapath widths, each sized to the range its value can reach.
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 64;
   localparam int ERR_W   = SPD_W + 2;
   localparam int NUM_W   = 21;
   localparam int NABS_W  = 20;
   localparam int FE_W    = 18;
   localparam int EI_W    = 15;
   localparam int SC_W    = 9;
   localparam int TABS_W  = 23;
   localparam int TURN_W  = 20;
   localparam int VEL_W   = 29;
   localparam int DWIDE_W = VEL_W + 9;
   localparam int DIFF_W  = 32;
   localparam int UPR_W   = 36;

   // Fixed-point shifts: Q11.20 gains, Q9.8 angles, combined gain and angle.
   localparam int GAIN_FRAC   = 20;
   localparam int ANGLE_FRAC  = 8;
   localparam int UPR_SHIFT   = 28;
   localparam int RECIP_SHIFT = 26;

   // Reciprocal of ten scaled by 2^26, exact for operands below about 11e6.
   localparam logic signed [MUL_W-1:0] RECIP10 = 33'sd6710887;

   // Command steps.
   localparam int SPEED_STEP = 25;
   localparam int STEER_STEP = 50;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_BALANCE_ANGLE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_UPRIGHT_P     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_UPRIGHT_D     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_P       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_I       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_STEER_P       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_LIMIT   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_STEER_LIMIT   = 3'd7;

   // Register reset values.
   localparam logic signed [ANGLE_W-1:0] RST_BALANCE_ANGLE = 18'sd333;
   localparam logic signed [GAIN_W-1:0]  RST_UPRIGHT_P     = -32'sd241172480;
   localparam logic signed [GAIN_W-1:0]  RST_UPRIGHT_D     = -32'sd2726298;
   localparam logic signed [GAIN_W-1:0]  RST_SPEED_P       = 32'sd167772;
   localparam logic signed [GAIN_W-1:0]  RST_SPEED_I       = 32'sd839;
   localparam logic signed [GAIN_W-1:0]  RST_STEER_P       = 32'sd41943040;

   // Operand pair codes for the shared multiplier.
   localparam logic [2:0] MUL_STEER    = 3'd0;
   localparam logic [2:0] MUL_DIV_NUM  = 3'd1;
   localparam logic [2:0] MUL_DIV_TURN = 3'd2;
   localparam logic [2:0] MUL_SPEED_P  = 3'd3;
   localparam logic [2:0] MUL_SPEED_I  = 3'd4;
   localparam logic [2:0] MUL_UP_P     = 3'd5;
   localparam logic [2:0] MUL_UP_D     = 3'd6;

   // Step strobes from the sequencer to the datapath.
   typedef struct packed {
      logic       idle;
      logic       num_en;
      logic       steer_en;
      logic       filt_en;
      logic       intg_en;
      logic       turn_en;
      logic       velp_en;
      logic       veli_en;
      logic       vel_en;
      logic       diff_en;
      logic       upd_en;
      logic       ups_en;
      logic       upr_en;
      logic       mix_en;
      logic [2:0] mul_sel;
   } ctrl_type;

endpackage

// ----- sv/balance_cascade_pid_unit.sv -----
// ----------------------------------------------------------------------------
// Balance cascade PID unit
// Cascaded speed, upright and turn controller for a two-wheeled balancing
// robot, computed on one shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
// One request beat is one control tick and gives one response beat with the
// two motor drives. A tick holds the unit for the accepting cycle in the idle
// step and fourteen steps after it; rsp_tvalid rises when the last step
// loads the response register. The seven products (steering, two divisions
// by ten, two speed terms, two upright terms) all pass one after another
// through the single registered multiplier. req_tready is high only while the
// sequencer is idle; a finished response may wait in its register while the
// next tick is taken. If a response is still waiting when the next tick
// reaches its last step, that step holds until the response register is free.
// The csr port is always ready and should be written only between ticks.
module balance_cascade_pid_unit #(
   parameter int PWM_LIMIT      = 7200,
   parameter int INTEGRAL_LIMIT = 10000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Fields from bit 0 up: go_forward, go_back, go_left, go_right,
   // left_wheel_speed, right_wheel_speed, roll_angle, roll_rate, yaw_rate.
   input  logic [bcp_pkg::REQ_W-1:0]            req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0 up: left_drive, right_drive.
   output logic [bcp_pkg::RSP_W-1:0]            rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bcp_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [bcp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import bcp_pkg::*;

   localparam logic signed [FE_W:0]    INT_HI  = (FE_W + 1)'(INTEGRAL_LIMIT);
   localparam logic signed [FE_W:0]    INT_LO  = -INT_HI;
   localparam logic signed [UPR_W:0]   PWM_HI  = (UPR_W + 1)'(PWM_LIMIT);
   localparam logic signed [UPR_W:0]   PWM_LO  = -PWM_HI;
   localparam logic signed [DWIDE_W-1:0] DIFF_HI =
      {{(DWIDE_W - DIFF_W + 1){1'b0}}, {(DIFF_W - 1){1'b1}}};
   localparam logic signed [DWIDE_W-1:0] DIFF_LO = -DIFF_HI;
   localparam logic signed [ACC_W-1:0] BIAS_GAIN =
      {{(ACC_W - GAIN_FRAC){1'b0}}, {GAIN_FRAC{1'b1}}};
   localparam logic signed [ACC_W-1:0] BIAS_UPR =
      {{(ACC_W - UPR_SHIFT){1'b0}}, {UPR_SHIFT{1'b1}}};

   ctrl_type ctrl;

   // Request fields.
   logic                      req_fwd, req_back, req_left, req_right;
   logic signed [SPD_W-1:0]   req_lspd, req_rspd;
   logic signed [ANGLE_W-1:0] req_roll;
   logic signed [RATE_W-1:0]  req_rrate, req_yrate;
   logic                      req_beat;

   // Configuration registers.
   logic signed [ANGLE_W-1:0] ba_ff;
   logic signed [GAIN_W-1:0]  up_ff, ud_ff, sp_ff, si_ff, st_ff;
   logic [LIM_W-1:0]          speed_limit_ff, steer_limit_ff;

   // Latched tick inputs.
   logic                      fwd_ff, back_ff, no_turn_ff;
   logic signed [SPD_W-1:0]   lspd_ff, rspd_ff;
   logic signed [ANGLE_W-1:0] roll_ff;
   logic signed [RATE_W-1:0]  rrate_ff, yrate_ff;

   // Controller state.
   logic signed [FE_W-1:0]    fe_ff, fe_in;
   logic signed [EI_W-1:0]    ei_ff, ei_in;
   logic signed [SC_W-1:0]    sc_ff, sc_in;

   // Working registers.
   logic [NABS_W-1:0]         num_abs_ff, num_abs_in;
   logic                      num_neg_ff;
   logic [TABS_W-1:0]         tabs_ff, tabs_in;
   logic                      tneg_ff;
   logic signed [TURN_W-1:0]  turn_ff, turn_in;
   logic signed [VEL_W-1:0]   vel_ff, vel_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [UPR_W-1:0]   upr_ff, upr_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   // Response register.
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] left_ff, right_ff, left_in, right_in;
   logic                      out_free;

   // Multiplier.
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   prod64;

   // Combinational helpers.
   logic signed [SC_W:0]      sc_sum, sc_lim;
   logic [LIM_W-1:0]          tgt_mag;
   logic signed [LIM_W:0]     tgt;
   logic signed [ERR_W-1:0]   err;
   logic signed [NUM_W-1:0]   err_n, fe_n, num;
   logic signed [FE_W-1:0]    fe_mag;
   logic signed [FE_W:0]      ei_sum;
   logic signed [ACC_W-1:0]   acc_abs, y64, y7, yaw_term, acc_rnd_vel, acc_rnd_upr;
   logic signed [TURN_W-1:0]  turn_mag;
   logic signed [DWIDE_W-1:0] diff_wide;
   logic signed [UPR_W:0]     left_wide, right_wide;

   // Unpack the request beat.
   assign req_fwd   = req_tdata[0];
   assign req_back  = req_tdata[1];
   assign req_left  = req_tdata[2];
   assign req_right = req_tdata[3];
   assign req_lspd  = $signed(req_tdata[19:4]);
   assign req_rspd  = $signed(req_tdata[35:20]);
   assign req_roll  = $signed(req_tdata[53:36]);
   assign req_rrate = $signed(req_tdata[69:54]);
   assign req_yrate = $signed(req_tdata[85:70]);

   assign req_tready = ctrl.idle;
   assign req_beat   = req_tvalid && ctrl.idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   bcp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_beat),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ba_ff          <= RST_BALANCE_ANGLE;
         up_ff          <= RST_UPRIGHT_P;
         ud_ff          <= RST_UPRIGHT_D;
         sp_ff          <= RST_SPEED_P;
         si_ff          <= RST_SPEED_I;
         st_ff          <= RST_STEER_P;
         speed_limit_ff <= '0;
         steer_limit_ff <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            REG_BALANCE_ANGLE: ba_ff          <= $signed(csr_wdata[ANGLE_W-1:0]);
            REG_UPRIGHT_P:     up_ff          <= $signed(csr_wdata[GAIN_W-1:0]);
            REG_UPRIGHT_D:     ud_ff          <= $signed(csr_wdata[GAIN_W-1:0]);
            REG_SPEED_P:       sp_ff          <= $signed(csr_wdata[GAIN_W-1:0]);
            REG_SPEED_I:       si_ff          <= $signed(csr_wdata[GAIN_W-1:0]);
            REG_STEER_P:       st_ff          <= $signed(csr_wdata[GAIN_W-1:0]);
            REG_SPEED_LIMIT:   speed_limit_ff <= csr_wdata[LIM_W-1:0];
            REG_STEER_LIMIT:   steer_limit_ff <= csr_wdata[LIM_W-1:0];
            default:           ba_ff          <= ba_ff;
         endcase
      end
   end

   // Steering command: cleared with no turn bit, else stepped and clamped.
   always_comb begin
      sc_lim = $signed({2'b00, steer_limit_ff});
      sc_sum = (SC_W + 1)'(sc_ff);
      if (req_left) begin
         sc_sum = sc_sum - (SC_W + 1)'(STEER_STEP);
      end
      if (req_right) begin
         sc_sum = sc_sum + (SC_W + 1)'(STEER_STEP);
      end
      if (!req_left && !req_right) begin
         sc_in = '0;
      end else if (sc_sum > sc_lim) begin
         sc_in = SC_W'(sc_lim);
      end else if (sc_sum < -sc_lim) begin
         sc_in = SC_W'(-sc_lim);
      end else begin
         sc_in = SC_W'(sc_sum);
      end
   end

   // Latch the tick inputs on the accepted request beat.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         fwd_ff     <= req_fwd;
         back_ff    <= req_back;
         no_turn_ff <= !req_left && !req_right;
         lspd_ff    <= req_lspd;
         rspd_ff    <= req_rspd;
         roll_ff    <= req_roll;
         rrate_ff   <= req_rrate;
         yrate_ff   <= req_yrate;
      end
   end

   // Target speed and the low-pass numerator 3*err + 7*filtered_error.
   always_comb begin
      tgt_mag = (speed_limit_ff < LIM_W'(SPEED_STEP)) ? speed_limit_ff
                                                      : LIM_W'(SPEED_STEP);
      if (back_ff) begin
         tgt = $signed({1'b0, tgt_mag});
      end else if (fwd_ff) begin
         tgt = -$signed({1'b0, tgt_mag});
      end else begin
         tgt = '0;
      end
      err        = ERR_W'(lspd_ff) + ERR_W'(rspd_ff) - ERR_W'(tgt);
      err_n      = NUM_W'(err);
      fe_n       = NUM_W'(fe_ff);
      num        = (err_n <<< 1) + err_n + (fe_n <<< 3) - fe_n;
      num_abs_in = num[NUM_W-1] ? NABS_W'(-num) : NABS_W'(num);
   end

   // Multiplier operand selection.
   always_comb begin
      case (ctrl.mul_sel)
         MUL_STEER: begin
            mul_a = MUL_W'(st_ff);
            mul_b = MUL_W'(sc_ff);
         end
         MUL_DIV_NUM: begin
            mul_a = $signed(MUL_W'(num_abs_ff));
            mul_b = RECIP10;
         end
         MUL_DIV_TURN: begin
            mul_a = $signed(MUL_W'(tabs_ff));
            mul_b = RECIP10;
         end
         MUL_SPEED_P: begin
            mul_a = MUL_W'(sp_ff);
            mul_b = MUL_W'(fe_ff);
         end
         MUL_SPEED_I: begin
            mul_a = MUL_W'(si_ff);
            mul_b = MUL_W'(ei_ff);
         end
         MUL_UP_P: begin
            mul_a = MUL_W'(up_ff);
            mul_b = MUL_W'(diff_ff);
         end
         MUL_UP_D: begin
            mul_a = MUL_W'(ud_ff);
            mul_b = MUL_W'(rrate_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   bcp_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign prod64 = $signed(prod_ff[ACC_W-1:0]);

   // Step arithmetic on the product, the accumulator and the state.
   always_comb begin
      y64      = ACC_W'(yrate_ff);
      y7       = (y64 <<< 3) - y64;
      yaw_term = no_turn_ff ? -(y7 <<< GAIN_FRAC) : '0;

      // Filtered error: quotient magnitude with the numerator's sign.
      fe_mag = $signed({1'b0, prod_ff[RECIP_SHIFT +: (FE_W - 1)]});
      fe_in  = num_neg_ff ? -fe_mag : fe_mag;

      // Turn numerator magnitude over 2^20, divided by ten later.
      acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
      tabs_in = acc_abs[GAIN_FRAC +: TABS_W];

      turn_mag = $signed({1'b0, prod_ff[RECIP_SHIFT +: (TURN_W - 1)]});
      turn_in  = tneg_ff ? -turn_mag : turn_mag;

      // Integral with its clamp.
      ei_sum = (FE_W + 1)'(ei_ff) + (FE_W + 1)'(fe_ff);
      if (ei_sum > INT_HI) begin
         ei_in = EI_W'(INT_HI);
      end else if (ei_sum < INT_LO) begin
         ei_in = EI_W'(INT_LO);
      end else begin
         ei_in = EI_W'(ei_sum);
      end

      // Divisions by powers of two, truncated toward zero.
      acc_rnd_vel = acc_ff + (acc_ff[ACC_W-1] ? BIAS_GAIN : '0);
      vel_in      = $signed(acc_rnd_vel[GAIN_FRAC +: VEL_W]);
      acc_rnd_upr = acc_ff + (acc_ff[ACC_W-1] ? BIAS_UPR : '0);
      upr_in      = $signed(acc_rnd_upr[UPR_SHIFT +: UPR_W]);

      // Upright set point error, saturated to the 32-bit range.
      diff_wide = DWIDE_W'(roll_ff) + DWIDE_W'(ba_ff) - (DWIDE_W'(vel_ff) <<< ANGLE_FRAC);
      if (diff_wide > DIFF_HI) begin
         diff_in = DIFF_W'(DIFF_HI);
      end else if (diff_wide < DIFF_LO) begin
         diff_in = DIFF_W'(DIFF_LO);
      end else begin
         diff_in = DIFF_W'(diff_wide);
      end

      // Drive mixing and clamping.
      left_wide  = (UPR_W + 1)'(upr_ff) - (UPR_W + 1)'(turn_ff);
      right_wide = (UPR_W + 1)'(upr_ff) + (UPR_W + 1)'(turn_ff);
      if (left_wide > PWM_HI) begin
         left_in = DRIVE_W'(PWM_HI);
      end else if (left_wide < PWM_LO) begin
         left_in = DRIVE_W'(PWM_LO);
      end else begin
         left_in = DRIVE_W'(left_wide);
      end
      if (right_wide > PWM_HI) begin
         right_in = DRIVE_W'(PWM_HI);
      end else if (right_wide < PWM_LO) begin
         right_in = DRIVE_W'(PWM_LO);
      end else begin
         right_in = DRIVE_W'(right_wide);
      end

      // Accumulator: loads, sums and the scaled steering term.
      acc_in = acc_ff;
      if (ctrl.steer_en) begin
         acc_in = (prod64 <<< 3) + (prod64 <<< 1) + yaw_term;
      end else if (ctrl.velp_en || ctrl.upd_en) begin
         acc_in = prod64;
      end else if (ctrl.veli_en) begin
         acc_in = acc_ff + prod64;
      end else if (ctrl.ups_en) begin
         acc_in = acc_ff - (prod64 <<< ANGLE_FRAC);
      end
   end

   // Controller state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         fe_ff <= '0;
         ei_ff <= '0;
         sc_ff <= '0;
      end else begin
         if (req_beat) begin
            sc_ff <= sc_in;
         end
         if (ctrl.filt_en) begin
            fe_ff <= fe_in;
         end
         if (ctrl.intg_en) begin
            ei_ff <= ei_in;
         end
      end
   end

   // Working registers of the step sequence.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.num_en) begin
         num_abs_ff <= num_abs_in;
         num_neg_ff <= num[NUM_W-1];
      end
      if (ctrl.filt_en) begin
         tabs_ff <= tabs_in;
         tneg_ff <= acc_ff[ACC_W-1];
      end
      if (ctrl.turn_en) begin
         turn_ff <= turn_in;
      end
      if (ctrl.vel_en) begin
         vel_ff <= vel_in;
      end
      if (ctrl.diff_en) begin
         diff_ff <= diff_in;
      end
      if (ctrl.upr_en) begin
         upr_ff <= upr_in;
      end
   end

   // Response register: loaded at the end of a tick when free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.mix_en && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mix_en && out_free) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - 2 * DRIVE_W){1'b0}}, right_ff, left_ff};

endmodule

// ----- sv/bcp_mul.sv -----
// ----------------------------------------------------------------------------
// Balance cascade PID shared multiplier
// Signed multiplier with a registered product, reused by every step that
// needs a product.
// ----------------------------------------------------------------------------
module bcp_mul (
   input  logic                                   clock,
   input  logic signed [bcp_pkg::MUL_W-1:0]        mul_a,
   input  logic signed [bcp_pkg::MUL_W-1:0]        mul_b,
   output logic signed [bcp_pkg::PROD_W-1:0]       prod_ff
);
   import bcp_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   // One product per cycle, held for the following step.
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/bcp_seq.sv -----
// ----------------------------------------------------------------------------
// Balance cascade PID sequencer
// Walks one control tick through its fixed list of steps and selects the
// multiplier operands for each step.
// ----------------------------------------------------------------------------
module bcp_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              out_free,
   output bcp_pkg::ctrl_type ctrl
);
   import bcp_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_NUM   = 4'd1;
   localparam logic [3:0] ST_STEER = 4'd2;
   localparam logic [3:0] ST_FILT  = 4'd3;
   localparam logic [3:0] ST_INTG  = 4'd4;
   localparam logic [3:0] ST_TURN  = 4'd5;
   localparam logic [3:0] ST_VELP  = 4'd6;
   localparam logic [3:0] ST_VELI  = 4'd7;
   localparam logic [3:0] ST_VEL   = 4'd8;
   localparam logic [3:0] ST_DIFF  = 4'd9;
   localparam logic [3:0] ST_UPP   = 4'd10;
   localparam logic [3:0] ST_UPD   = 4'd11;
   localparam logic [3:0] ST_UPS   = 4'd12;
   localparam logic [3:0] ST_UPR   = 4'd13;
   localparam logic [3:0] ST_MIX   = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next step: a straight walk, waiting only for a beat and a free output.
   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = start ? ST_NUM : ST_IDLE;
         ST_NUM:   state_in = ST_STEER;
         ST_STEER: state_in = ST_FILT;
         ST_FILT:  state_in = ST_INTG;
         ST_INTG:  state_in = ST_TURN;
         ST_TURN:  state_in = ST_VELP;
         ST_VELP:  state_in = ST_VELI;
         ST_VELI:  state_in = ST_VEL;
         ST_VEL:   state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_UPP;
         ST_UPP:   state_in = ST_UPD;
         ST_UPD:   state_in = ST_UPS;
         ST_UPS:   state_in = ST_UPR;
         ST_UPR:   state_in = ST_MIX;
         ST_MIX:   state_in = out_free ? ST_IDLE : ST_MIX;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step strobes and multiplier operand selection.
   always_comb begin
      ctrl         = '0;
      ctrl.mul_sel = MUL_STEER;
      case (state_ff)
         ST_IDLE:  ctrl.idle = 1'b1;
         ST_NUM:   ctrl.num_en = 1'b1;
         ST_STEER: begin
            ctrl.steer_en = 1'b1;
            ctrl.mul_sel  = MUL_DIV_NUM;
         end
         ST_FILT:  ctrl.filt_en = 1'b1;
         ST_INTG:  begin
            ctrl.intg_en = 1'b1;
            ctrl.mul_sel = MUL_DIV_TURN;
         end
         ST_TURN:  begin
            ctrl.turn_en = 1'b1;
            ctrl.mul_sel = MUL_SPEED_P;
         end
         ST_VELP:  begin
            ctrl.velp_en = 1'b1;
            ctrl.mul_sel = MUL_SPEED_I;
         end
         ST_VELI:  ctrl.veli_en = 1'b1;
         ST_VEL:   ctrl.vel_en = 1'b1;
         ST_DIFF:  ctrl.diff_en = 1'b1;
         ST_UPP:   ctrl.mul_sel = MUL_UP_P;
         ST_UPD:   begin
            ctrl.upd_en  = 1'b1;
            ctrl.mul_sel = MUL_UP_D;
         end
         ST_UPS:   ctrl.ups_en = 1'b1;
         ST_UPR:   ctrl.upr_en = 1'b1;
         ST_MIX:   ctrl.mix_en = 1'b1;
         default:  ctrl.idle = 1'b0;
      endcase
   end

endmodule
